>>> hw/rtl/ffp_pkg.sv
`default_nettype none

package ffp_pkg;

  // Significant bytes of the file formats
  localparam logic [7:0] CH_FASTA   = 8'h3E;  // '>'
  localparam logic [7:0] CH_FASTQ   = 8'h40;  // '@'
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_COMMENT = 8'h23;  // '#'
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned SKIP_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BREAK = 2'd1;

  localparam logic [SKIP_W-1:0] SKIP_MASK_RST  = 3'd0;
  localparam logic [7:0]        LINE_BREAK_RST = CH_LF;

  // Bit positions in skip_mask
  localparam int unsigned SKIP_HDR  = 0;
  localparam int unsigned SKIP_SEQ  = 1;
  localparam int unsigned SKIP_QUAL = 2;

  typedef enum logic [1:0] {
    FMT_NONE    = 2'd0,
    FMT_FASTA   = 2'd1,
    FMT_FASTQ   = 2'd2,
    FMT_UNKNOWN = 2'd3
  } fmt_t;

  // FASTA only uses PH_IDLE and PH_HEADER (record open)
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_HEADER    = 2'd1,
    PH_WAIT_PLUS = 2'd2,
    PH_QUAL      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_IGNORE = 2'd0,
    ROLE_HDR    = 2'd1,
    ROLE_SEQ    = 2'd2,
    ROLE_QUAL   = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_SEQ    = 3'd1,
    KIND_QUAL   = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_DROP   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       in_name;
    logic [1:0] format;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/ffp_core.sv
`default_nettype none

module ffp_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ffp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ffp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          acc,
  input  wire ffp_pkg::in_item_t             item,
  output logic                               res_vld,
  output ffp_pkg::out_item_t                 res
);

  logic [ffp_pkg::SKIP_W-1:0] skip_mask_r;
  logic [7:0]                 line_break_r;

  ffp_pkg::fmt_t   fmt_r,   fmt_nxt;
  ffp_pkg::phase_t phase_r, phase_nxt;
  ffp_pkg::role_t  role_r,  role_nxt;
  logic            start_r, start_nxt;
  logic            name_r,  name_nxt;
  logic            has_r,   has_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_mask_r  <= ffp_pkg::SKIP_MASK_RST;
      line_break_r <= ffp_pkg::LINE_BREAK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ffp_pkg::CFG_SKIP_MASK:  skip_mask_r  <= cfg_data[ffp_pkg::SKIP_W-1:0];
        ffp_pkg::CFG_LINE_BREAK: line_break_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]      b;
    ffp_pkg::fmt_t   fmt_eff;
    ffp_pkg::role_t  role_eff;
    logic            emit;
    logic            ws;
    logic            name_eff;

    b        = item.data_byte;
    fmt_eff  = fmt_r;
    role_eff = role_r;
    emit     = 1'b1;
    ws       = (b == ffp_pkg::CH_SPACE) || (b == ffp_pkg::CH_TAB) ||
               (b == ffp_pkg::CH_CR) || (b == ffp_pkg::CH_LF);
    name_eff = name_r && !ws;

    fmt_nxt   = fmt_r;
    phase_nxt = phase_r;
    role_nxt  = role_r;
    start_nxt = start_r;
    name_nxt  = name_r;
    has_nxt   = has_r;

    res_vld     = 1'b0;
    res.out_byte = 8'd0;
    res.kind     = ffp_pkg::KIND_DONE;
    res.in_name  = 1'b0;
    res.format   = fmt_r;

    if (item.stream_end) begin
      // close or drop the open record, then start afresh
      if (fmt_r == ffp_pkg::FMT_FASTA && phase_r != ffp_pkg::PH_IDLE) begin
        res_vld = 1'b1;
      end else if (fmt_r == ffp_pkg::FMT_FASTQ && phase_r != ffp_pkg::PH_IDLE) begin
        res_vld = 1'b1;
        if (!(phase_r == ffp_pkg::PH_QUAL && role_r == ffp_pkg::ROLE_QUAL && has_r))
          res.kind = ffp_pkg::KIND_DROP;
      end
      fmt_nxt   = ffp_pkg::FMT_NONE;
      phase_nxt = ffp_pkg::PH_IDLE;
      role_nxt  = ffp_pkg::ROLE_IGNORE;
      start_nxt = 1'b1;
      name_nxt  = 1'b0;
      has_nxt   = 1'b0;
    end else if (fmt_r == ffp_pkg::FMT_UNKNOWN) begin
      // drop everything until end of stream
    end else if (b == line_break_r) begin
      if (fmt_r == ffp_pkg::FMT_FASTQ) begin
        if (start_r && phase_r == ffp_pkg::PH_HEADER) begin
          phase_nxt = ffp_pkg::PH_WAIT_PLUS;
        end else if ((start_r && phase_r == ffp_pkg::PH_QUAL) ||
                     role_r == ffp_pkg::ROLE_QUAL) begin
          res_vld   = 1'b1;
          phase_nxt = ffp_pkg::PH_IDLE;
        end
      end
      start_nxt = 1'b1;
      role_nxt  = ffp_pkg::ROLE_IGNORE;
      name_nxt  = 1'b0;
      has_nxt   = 1'b0;
    end else begin
      if (start_r) begin
        start_nxt = 1'b0;
        has_nxt   = 1'b1;
        if (fmt_r == ffp_pkg::FMT_NONE) begin
          if (b == ffp_pkg::CH_COMMENT) begin
            role_nxt = ffp_pkg::ROLE_IGNORE;
            emit     = 1'b0;
          end else if (b == ffp_pkg::CH_FASTA) begin
            fmt_eff = ffp_pkg::FMT_FASTA;
          end else if (b == ffp_pkg::CH_FASTQ) begin
            fmt_eff = ffp_pkg::FMT_FASTQ;
          end else begin
            fmt_eff = ffp_pkg::FMT_UNKNOWN;
            emit    = 1'b0;
          end
        end
        fmt_nxt    = fmt_eff;
        res.format = fmt_eff;
        if (emit && fmt_eff == ffp_pkg::FMT_FASTA) begin
          if (b == ffp_pkg::CH_FASTA) begin
            // a new header closes the previous record
            res_vld   = (phase_r != ffp_pkg::PH_IDLE);
            phase_nxt = ffp_pkg::PH_HEADER;
            role_nxt  = ffp_pkg::ROLE_HDR;
            name_nxt  = 1'b1;
            emit      = 1'b0;
          end else begin
            role_eff = (phase_r != ffp_pkg::PH_IDLE) ? ffp_pkg::ROLE_SEQ
                                                     : ffp_pkg::ROLE_IGNORE;
          end
        end else if (emit) begin
          case (phase_r)
            ffp_pkg::PH_IDLE: begin
              if (b == ffp_pkg::CH_FASTQ) begin
                phase_nxt = ffp_pkg::PH_HEADER;
                role_nxt  = ffp_pkg::ROLE_HDR;
                name_nxt  = 1'b1;
              end else begin
                role_nxt = ffp_pkg::ROLE_IGNORE;
              end
              emit = 1'b0;
            end
            ffp_pkg::PH_HEADER: begin
              phase_nxt = ffp_pkg::PH_WAIT_PLUS;
              role_eff  = ffp_pkg::ROLE_SEQ;
            end
            ffp_pkg::PH_WAIT_PLUS: begin
              if (b == ffp_pkg::CH_PLUS) phase_nxt = ffp_pkg::PH_QUAL;
              role_nxt = ffp_pkg::ROLE_IGNORE;
              emit     = 1'b0;
            end
            default: role_eff = ffp_pkg::ROLE_QUAL;
          endcase
        end
      end
      if (emit) begin
        role_nxt     = role_eff;
        res.out_byte = b;
        case (role_eff)
          ffp_pkg::ROLE_HDR: begin
            name_nxt    = name_eff;
            res_vld     = !skip_mask_r[ffp_pkg::SKIP_HDR];
            res.kind    = ffp_pkg::KIND_HEADER;
            res.in_name = name_eff;
          end
          ffp_pkg::ROLE_SEQ: begin
            res_vld  = !skip_mask_r[ffp_pkg::SKIP_SEQ];
            res.kind = ffp_pkg::KIND_SEQ;
          end
          ffp_pkg::ROLE_QUAL: begin
            res_vld  = !skip_mask_r[ffp_pkg::SKIP_QUAL];
            res.kind = ffp_pkg::KIND_QUAL;
          end
          default: res.out_byte = 8'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= ffp_pkg::FMT_NONE;
      phase_r <= ffp_pkg::PH_IDLE;
      role_r  <= ffp_pkg::ROLE_IGNORE;
      start_r <= 1'b1;
      name_r  <= 1'b0;
      has_r   <= 1'b0;
    end else if (acc) begin
      fmt_r   <= fmt_nxt;
      phase_r <= phase_nxt;
      role_r  <= role_nxt;
      start_r <= start_nxt;
      name_r  <= name_nxt;
      has_r   <= has_nxt;
    end
  end

  // format is sticky until end of stream
  a_fmt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fmt_r != ffp_pkg::FMT_NONE && !(acc && item.stream_end)) |=> $stable(fmt_r))
    else $error("detected format changed inside a stream");

  a_fasta_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (fmt_r == ffp_pkg::FMT_FASTA) |->
      (phase_r == ffp_pkg::PH_IDLE || phase_r == ffp_pkg::PH_HEADER))
    else $error("FASTA record phase out of range");

  a_name_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    name_r |-> (role_r == ffp_pkg::ROLE_HDR))
    else $error("name open outside a header line");

endmodule

`default_nettype wire

>>> hw/rtl/ffp_skid.sv
`default_nettype none

module ffp_skid (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ffp_pkg::out_item_t push_data,
  output logic                    space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ffp_pkg::out_item_t      out_data
);

  logic               main_vld_r, main_vld_nxt;
  logic               skid_vld_r, skid_vld_nxt;
  ffp_pkg::out_item_t main_r, main_nxt;
  ffp_pkg::out_item_t skid_r, skid_nxt;

  // skid empty means a new word can always be absorbed
  assign space     = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (!main_vld_r || out_ready) begin
      // advance: skid first, else the new word
      main_vld_nxt = skid_vld_r || push;
      main_nxt     = skid_vld_r ? skid_r : push_data;
      skid_vld_nxt = 1'b0;
    end else if (push) begin
      // hold the new word behind the stalled one
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid word without a word in front of it");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_vld_r)
    else $error("word pushed into full buffer");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (main_vld_r && !out_ready && push) |=> skid_vld_r)
    else $error("word lost on stalled output");

endmodule

`default_nettype wire

>>> hw/rtl/fasta_fastq_record_parser.sv
`default_nettype none

// Tags a FASTA or FASTQ byte stream, one byte per cycle: each accepted input
// word is parsed in the cycle it is taken and gives at most one result word
// (header, name, sequence or quality byte, or a record complete/dropped
// marker). Input is accepted every cycle while the two-word output buffer has
// room, so throughput is one byte per clock whenever out_ready keeps up; a
// result is registered in the buffer's main or skid word before out_valid.
// A word with stream_end set flushes the open record and rearms format
// detection. cfg_ready is always high; write registers only while idle.

module fasta_fastq_record_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ffp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ffp_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ffp_pkg::out_item_t                  out_data
);

  logic               acc;
  logic               res_vld;
  ffp_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;

  ffp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_wdata),
    .acc      (acc),
    .item     (in_data),
    .res_vld  (res_vld),
    .res      (res)
  );

  ffp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_vld),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
